>>> sv/wavh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the WAVE header field extractor.
// Used by the scanner, the divider, the top level and the checker.

package wavh_pkg;

  localparam int POSITION_BITS = 32;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [4:0] FMT_SKIP    = 5'd4;
  localparam logic [4:0] FMT_END     = 5'd20;
  localparam logic [2:0] LEN_BYTES   = 3'd4;
  localparam logic [3:0] DATA_HEADER = 4'd8;

  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_RIFF    = 3'd1;
  localparam logic [2:0] ST_NO_FMT     = 3'd2;
  localparam logic [2:0] ST_NO_DATA    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_ZERO_ALIGN = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wavh_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [31:0] sample_rate;
    logic [12:0] bytes_per_sample;
    logic [15:0] channel_count;
    logic [31:0] sample_frames;
    logic [31:0] data_offset;
  } wavh_out_t;

  // Scanner state as seen by the result logic.
  typedef struct packed {
    logic                     riff_seen;
    logic                     fmt_seen;
    logic                     data_seen;
    logic                     fmt_full;
    logic                     len_full;
    logic [127:0]             fmt_body;
    logic [31:0]              chunk_length;
    logic [POSITION_BITS-1:0] data_tag_position;
  } wavh_scan_t;

endpackage

>>> sv/wavh_scan.sv
`timescale 1ns / 1ps
// Byte scanner: tag search over a three-byte history and field capture.
// Depends on wavh_pkg.

module wavh_scan import wavh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       take,
  input  logic [7:0] data_byte,
  output wavh_scan_t scan
);

  logic [23:0]              recent_bytes;
  logic [POSITION_BITS-1:0] byte_position;
  logic                     riff_seen;
  logic                     fmt_seen;
  logic                     data_seen;
  logic [4:0]               fmt_capture_count;
  logic [2:0]               len_capture_count;
  logic [127:0]             fmt_body;
  logic [31:0]              chunk_length;
  logic [POSITION_BITS-1:0] data_tag_position;
  logic [31:0]              window;
  logic [3:0]               body_index;

  assign window     = {recent_bytes, data_byte};
  assign body_index = 4'(fmt_capture_count - FMT_SKIP);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      recent_bytes      <= '0;
      byte_position     <= '0;
      riff_seen         <= 1'b0;
      fmt_seen          <= 1'b0;
      data_seen         <= 1'b0;
      fmt_capture_count <= '0;
      len_capture_count <= '0;
    end else if (take) begin
      // Captures look at the state before this byte, so the byte that
      // completes a tag is never part of its own capture.
      if (fmt_seen && fmt_capture_count < FMT_END) begin
        if (fmt_capture_count >= FMT_SKIP) begin
          fmt_body[body_index*8 +: 8] <= data_byte;
        end
        fmt_capture_count <= fmt_capture_count + 5'd1;
      end
      if (data_seen && len_capture_count < LEN_BYTES) begin
        chunk_length[len_capture_count[1:0]*8 +: 8] <= data_byte;
        len_capture_count <= len_capture_count + 3'd1;
      end
      if (!riff_seen && window == TAG_RIFF) begin
        riff_seen <= 1'b1;
      end
      if (!fmt_seen && window == TAG_FMT) begin
        fmt_seen <= 1'b1;
      end
      if (!data_seen && window == TAG_DATA) begin
        data_seen         <= 1'b1;
        data_tag_position <= byte_position - POSITION_BITS'(3);
      end
      recent_bytes  <= window[23:0];
      byte_position <= byte_position + POSITION_BITS'(1);
    end
  end

  always_comb begin
    scan.riff_seen         = riff_seen;
    scan.fmt_seen          = fmt_seen;
    scan.data_seen         = data_seen;
    scan.fmt_full          = (fmt_capture_count == FMT_END);
    scan.len_full          = (len_capture_count == LEN_BYTES);
    scan.fmt_body          = fmt_body;
    scan.chunk_length      = chunk_length;
    scan.data_tag_position = data_tag_position;
  end

endmodule

>>> sv/wavh_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on wavh_pkg.

module wavh_div import wavh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      count;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  assign shifted  = {rem, quo[DIVIDEND_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dsr};
  assign fits     = !diff[DIVISOR_W+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && count == '0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      dsr   <= divisor;
      count <= CNT_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      quo   <= {quo[DIVIDEND_W-2:0], fits};
      rem   <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      count <= count - CNT_W'(1);
    end
  end

endmodule

>>> sv/wav_header_field_extractor.sv
`timescale 1ns / 1ps
// Top level of the WAVE header field extractor: handshakes, result logic.
// Depends on wavh_pkg, wavh_scan and wavh_div.
//
//   Channel  Handshake               Word type    Content
//   byte     byte_valid/byte_stall   wavh_in_t    one buffer byte plus end mark
//   info     info_valid/info_stall   wavh_out_t   header fields and status
//
// A byte without the end mark causes no stall, so bytes stream back to back.
// After the last byte the input stalls through the evaluation state, which
// waits for a free output register; a failed header gives its result at the
// end of it, a good one then runs the frame-count division through the
// divider, one quotient bit per cycle, with the input still stalled. A result
// that is not yet taken holds the output register but not the input: bytes of
// the next buffer keep flowing until its own last byte needs the register.
// Reset is synchronous and clears the scanner, the sequencer and the valid flag.

module wav_header_field_extractor import wavh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  wavh_in_t  byte_word,
  output logic      info_valid,
  input  logic      info_stall,
  output wavh_out_t info_word
);

  localparam logic [1:0] S_SCAN = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  wavh_scan_t            scan;
  logic                  take;
  logic                  out_free;
  logic                  eval_go;
  logic [2:0]            status;
  logic [15:0]           block_align;
  wavh_out_t             result;
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;

  assign byte_stall = (state != S_SCAN);
  assign take       = byte_valid && !byte_stall;

  // The output register is free when empty or being emptied this cycle.
  assign out_free  = !info_valid || !info_stall;
  assign eval_go   = (state == S_EVAL) && out_free;
  assign div_start = eval_go && status == ST_OK;

  wavh_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (eval_go),
    .take      (take),
    .data_byte (byte_word.data_byte),
    .scan      (scan)
  );

  assign block_align = scan.fmt_body[111:96];

  // Checks in priority order: missing tags first, then truncation, then a
  // zero block align that would make the division meaningless.
  always_comb begin
    priority if (!scan.riff_seen) begin
      status = ST_NO_RIFF;
    end else if (!scan.fmt_seen) begin
      status = ST_NO_FMT;
    end else if (!scan.data_seen) begin
      status = ST_NO_DATA;
    end else if (!scan.fmt_full || !scan.len_full) begin
      status = ST_TRUNCATED;
    end else if (block_align == '0) begin
      status = ST_ZERO_ALIGN;
    end else begin
      status = ST_OK;
    end
  end

  // A failed result carries only its status; every other field is zero.
  always_comb begin
    result        = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.format_tag       = scan.fmt_body[15:0];
      result.channel_count    = scan.fmt_body[31:16];
      result.sample_rate      = scan.fmt_body[63:32];
      result.bytes_per_sample = scan.fmt_body[127:115];
      result.data_offset      =
        32'(scan.data_tag_position + POSITION_BITS'(DATA_HEADER));
    end
  end

  wavh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scan.chunk_length),
    .divisor  (block_align),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_SCAN: begin
        if (take && byte_word.last_byte) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (eval_go) begin
          state_next = (status == ST_OK) ? S_DIV : S_SCAN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_SCAN;
      end
    endcase
  end

  // A new result takes priority over the handshake that empties the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SCAN;
      info_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((eval_go && status != ST_OK) || (state == S_DIV && div_done)) begin
        info_valid <= 1'b1;
      end else if (info_valid && !info_stall) begin
        info_valid <= 1'b0;
      end
    end
  end

  // The word is loaded only when the register is free, and the frame count
  // lands while the valid flag is still low, so a stalled word never moves.
  always_ff @(posedge clk) begin
    if (eval_go) begin
      info_word <= result;
    end else if (state == S_DIV && div_done) begin
      info_word.sample_frames <= quotient;
    end
  end

endmodule

>>> sv/wavh_check.sv
`timescale 1ns / 1ps
// Port-level checker for the WAVE header field extractor, bound to the top.
// Depends on wavh_pkg.

module wavh_check import wavh_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_stall,
  input wavh_in_t  byte_word,
  input logic      info_valid,
  input logic      info_stall,
  input wavh_out_t info_word
);

  // A stalled result word stays up and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    info_valid && info_stall |=> info_valid && $stable(info_word))
    else $error("stalled result word changed");

  assert property (@(posedge clk) disable iff (rst)
    info_valid |-> info_word.status <= ST_ZERO_ALIGN)
    else $error("result status out of range");

  assert property (@(posedge clk) disable iff (rst)
    info_valid && info_word.status != ST_OK |->
      info_word.format_tag == '0 && info_word.sample_rate == '0 &&
      info_word.bytes_per_sample == '0 && info_word.channel_count == '0 &&
      info_word.sample_frames == '0 && info_word.data_offset == '0)
    else $error("failed result carries nonzero fields");

  // The input stalls right after the last byte of a buffer is taken.
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && byte_word.last_byte |=> byte_stall)
    else $error("byte taken right after a last byte");

endmodule

bind wav_header_field_extractor wavh_check u_wavh_check (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_word  (byte_word),
  .info_valid (info_valid),
  .info_stall (info_stall),
  .info_word  (info_word)
);
